@@ rtl/bdt_pkg.sv @@
// ----------------------------------------------------------------------------
// bdt_pkg
// Widths, constants and calendar tables for the broken-down time converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bdt_pkg;

  localparam int YEAR_IN_W = 13;
  localparam int MONTH_W   = 4;
  localparam int DAY_W     = 6;
  localparam int HOUR_W    = 5;
  localparam int MIN_W     = 6;
  localparam int SEC_W     = 6;
  localparam int YEAR_W    = 14;
  localparam int QUOT_W    = 8;
  localparam int DAYS_W    = 22;
  localparam int TOD_W     = 17;
  localparam int SECS_W    = 38;
  localparam int YDAY_W    = 9;

  // Quotient by 100 as (value * 10486) >> 20, exact for all 14-bit values.
  localparam int DIV100_MUL_W = 14;
  localparam int DIV100_SHIFT = 20;
  localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 14'd10486;

  localparam logic [YEAR_W-1:0] BASE_YEAR          = 14'd1900;
  localparam logic [YEAR_W-1:0] EPOCH_YEAR         = 14'd1970;
  localparam logic [YEAR_W-1:0] LEAPS_BEFORE_EPOCH = 14'd477;

  localparam logic [HOUR_W-1:0] LAST_HOUR   = 5'd23;
  localparam logic [MIN_W-1:0]  LAST_MINUTE = 6'd59;
  localparam logic [SEC_W-1:0]  LAST_SECOND = 6'd59;

  localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_MAR  = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_LAST = 4'd11;

  localparam logic [TOD_W-1:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [TOD_W-1:0] SECS_PER_MIN  = 17'd60;
  localparam logic [TOD_W-1:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [8:0]       DAYS_PER_YEAR = 9'd365;
  localparam logic [6:0]       CENTURY       = 7'd100;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] mon);
    logic [DAY_W-1:0] len;
    case (mon)
      4'd0:    len = 6'd31;
      4'd1:    len = 6'd28;
      4'd2:    len = 6'd31;
      4'd3:    len = 6'd30;
      4'd4:    len = 6'd31;
      4'd5:    len = 6'd30;
      4'd6:    len = 6'd31;
      4'd7:    len = 6'd31;
      4'd8:    len = 6'd30;
      4'd9:    len = 6'd31;
      4'd10:   len = 6'd30;
      4'd11:   len = 6'd31;
      default: len = 6'd0;
    endcase
    return len;
  endfunction

  function automatic logic [YDAY_W-1:0] days_before(input logic [MONTH_W-1:0] mon);
    logic [YDAY_W-1:0] d;
    case (mon)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

@@ rtl/bdt_div100.sv @@
// ----------------------------------------------------------------------------
// bdt_div100
// Registered quotient of a year by 100 through a reciprocal multiply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdt_div100
  import bdt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [YEAR_W-1:0] value,
  output logic      [QUOT_W-1:0] quot
);

  logic [YEAR_W+DIV100_MUL_W-1:0] prod;

  assign prod = (YEAR_W+DIV100_MUL_W)'(value) * (YEAR_W+DIV100_MUL_W)'(DIV100_MUL);

  always_ff @(posedge clk) begin
    if (en) begin
      quot <= prod[DIV100_SHIFT +: QUOT_W];
    end
  end

endmodule

`default_nettype wire

@@ rtl/broken_down_time_to_epoch_seconds.sv @@
// ----------------------------------------------------------------------------
// broken_down_time_to_epoch_seconds
// Converts a broken-down UTC time into seconds since 1970-01-01 00:00.
//
// Input channel: in_valid / in_stall with one port per time field. Output
// channel: out_valid / out_stall carrying epoch_seconds and time_valid.
// An item is taken at a clock edge where valid is high and stall is low.
// The datapath is a five-stage pipeline: year offset and range checks,
// division of the year by 100, leap rule and day check, day and time-of-day
// sums, and the final multiply by 86400. Throughput is one item per cycle
// while out_stall is low. Each stage holds its item while the next stage
// is full and stalled, and empty stages still advance, so a stall on the
// output drops and repeats nothing. in_stall rises only when every stage
// is full. A time with any field out of range comes out with time_valid
// low and epoch_seconds zero. Reset empties the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module broken_down_time_to_epoch_seconds
  import bdt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [YEAR_IN_W-1:0] years_since_1900,
  input  wire logic [MONTH_W-1:0]   month_index,
  input  wire logic [DAY_W-1:0]     day_of_month,
  input  wire logic [HOUR_W-1:0]    hour_of_day,
  input  wire logic [MIN_W-1:0]     minute_of_hour,
  input  wire logic [SEC_W-1:0]     second_of_minute,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [SECS_W-1:0]         epoch_seconds,
  output logic                      time_valid
);

  logic v1, v2, v3, v4;
  logic adv1, adv2, adv3, adv4, adv5;

  // stage 1
  logic [YEAR_W-1:0]  s1_year, s1_yearm1;
  logic [MONTH_W-1:0] s1_mon;
  logic [DAY_W-1:0]   s1_mday;
  logic [HOUR_W-1:0]  s1_hr;
  logic [MIN_W-1:0]   s1_mn;
  logic [SEC_W-1:0]   s1_sc;
  logic               s1_ok;
  logic [YEAR_W-1:0]  year_in;

  // stage 2
  logic [YEAR_W-1:0]  s2_year, s2_yearm1;
  logic [QUOT_W-1:0]  s2_qy, s2_qn;
  logic [MONTH_W-1:0] s2_mon;
  logic [DAY_W-1:0]   s2_mday;
  logic [HOUR_W-1:0]  s2_hr;
  logic [MIN_W-1:0]   s2_mn;
  logic [SEC_W-1:0]   s2_sc;
  logic               s2_ok;

  // stage 3
  logic [YEAR_W-1:0]  s3_year_off, s3_leaps;
  logic               s3_leap;
  logic [MONTH_W-1:0] s3_mon;
  logic [DAY_W-1:0]   s3_mday;
  logic [HOUR_W-1:0]  s3_hr;
  logic [MIN_W-1:0]   s3_mn;
  logic [SEC_W-1:0]   s3_sc;
  logic               s3_ok;
  logic [14:0]        cent_prod;
  logic               leap_next;
  logic [DAY_W-1:0]   len_next;
  logic               day_ok_next;
  logic [YEAR_W-1:0]  leaps_next;

  // stage 4
  logic [DAYS_W-1:0]  s4_days;
  logic [TOD_W-1:0]   s4_tod;
  logic               s4_ok;
  logic [DAYS_W-1:0]  days_next;
  logic [TOD_W-1:0]   tod_next;

  // stage 5
  logic [SECS_W-1:0]  secs_next;

  assign adv5 = !out_valid || !out_stall;
  assign adv4 = !v4 || adv5;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign in_stall = !adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
      if (adv5) out_valid <= v4;
    end
  end

  // stage 1: year and field range checks
  assign year_in = YEAR_W'(years_since_1900) + BASE_YEAR;

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_year   <= year_in;
      s1_yearm1 <= year_in - YEAR_W'(1);
      s1_mon    <= month_index;
      s1_mday   <= day_of_month;
      s1_hr     <= hour_of_day;
      s1_mn     <= minute_of_hour;
      s1_sc     <= second_of_minute;
      s1_ok     <= (year_in >= EPOCH_YEAR) && (month_index <= MONTH_LAST) &&
                   (hour_of_day <= LAST_HOUR) && (minute_of_hour <= LAST_MINUTE) &&
                   (second_of_minute <= LAST_SECOND);
    end
  end

  // stage 2: centuries of the year and of the year before
  bdt_div100 u_div_year (
    .clk   (clk),
    .en    (adv2),
    .value (s1_year),
    .quot  (s2_qy)
  );

  bdt_div100 u_div_prev (
    .clk   (clk),
    .en    (adv2),
    .value (s1_yearm1),
    .quot  (s2_qn)
  );

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_year   <= s1_year;
      s2_yearm1 <= s1_yearm1;
      s2_mon    <= s1_mon;
      s2_mday   <= s1_mday;
      s2_hr     <= s1_hr;
      s2_mn     <= s1_mn;
      s2_sc     <= s1_sc;
      s2_ok     <= s1_ok;
    end
  end

  // stage 3: leap rule, day check, leap days since the epoch
  assign cent_prod   = 15'(s2_qy) * 15'(CENTURY);
  assign leap_next   = (s2_year[1:0] == 2'b00) &&
                       ((cent_prod != 15'(s2_year)) || (s2_qy[1:0] == 2'b00));
  assign len_next    = month_len(s2_mon) +
                       DAY_W'(leap_next && (s2_mon == MONTH_FEB));
  assign day_ok_next = (s2_mday != '0) && (s2_mday <= len_next);
  assign leaps_next  = (s2_yearm1 >> 2) - YEAR_W'(s2_qn) + YEAR_W'(s2_qn >> 2) -
                       LEAPS_BEFORE_EPOCH;

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_year_off <= s2_year - EPOCH_YEAR;
      s3_leaps    <= leaps_next;
      s3_leap     <= leap_next;
      s3_mon      <= s2_mon;
      s3_mday     <= s2_mday;
      s3_hr       <= s2_hr;
      s3_mn       <= s2_mn;
      s3_sc       <= s2_sc;
      s3_ok       <= s2_ok && day_ok_next;
    end
  end

  // stage 4: whole days and seconds of the day
  assign days_next = DAYS_W'(s3_year_off) * DAYS_W'(DAYS_PER_YEAR) +
                     DAYS_W'(days_before(s3_mon)) + DAYS_W'(s3_mday) - DAYS_W'(1) +
                     DAYS_W'(s3_leaps) + DAYS_W'(s3_leap && (s3_mon >= MONTH_MAR));
  assign tod_next  = TOD_W'(s3_hr) * SECS_PER_HOUR + TOD_W'(s3_mn) * SECS_PER_MIN +
                     TOD_W'(s3_sc);

  always_ff @(posedge clk) begin
    if (adv4) begin
      s4_days <= days_next;
      s4_tod  <= tod_next;
      s4_ok   <= s3_ok;
    end
  end

  // stage 5: scale days to seconds, zero on invalid
  assign secs_next = SECS_W'(s4_days) * SECS_W'(SECS_PER_DAY) + SECS_W'(s4_tod);

  always_ff @(posedge clk) begin
    if (adv5) begin
      epoch_seconds <= s4_ok ? secs_next : '0;
      time_valid    <= s4_ok;
    end
  end

endmodule

`default_nettype wire

@@ verif/bdt_epoch_checker.sv @@
// ----------------------------------------------------------------------------
// bdt_epoch_checker
// Watches both channels of the broken-down time converter. Every accepted
// input item is turned into an expected epoch count and valid flag, kept in
// arrival order, and every accepted result is compared field by field
// against the oldest expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdt_epoch_checker
  import bdt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [YEAR_IN_W-1:0] years_since_1900,
  input  logic [MONTH_W-1:0]   month_index,
  input  logic [DAY_W-1:0]     day_of_month,
  input  logic [HOUR_W-1:0]    hour_of_day,
  input  logic [MIN_W-1:0]     minute_of_hour,
  input  logic [SEC_W-1:0]     second_of_minute,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [SECS_W-1:0]    epoch_seconds,
  input  logic                 time_valid,
  output int                   mismatches,
  output int                   outstanding
);

  typedef struct packed {
    logic [SECS_W-1:0] secs;
    logic              ok;
  } epoch_t;

  localparam int unsigned DAYS_IN_MONTH [12] = '{31, 28, 31, 30, 31, 30,
                                                 31, 31, 30, 31, 30, 31};

  epoch_t epoch_q[$];
  int     err_count = 0;
  int     wait_count = 0;

  assign mismatches  = err_count;
  assign outstanding = wait_count;

  function automatic bit leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic longint unsigned leap_days_through(input int unsigned y);
    return longint'(y / 4) - longint'(y / 100) + longint'(y / 400);
  endfunction

  function automatic epoch_t civil_to_epoch(
    input logic [YEAR_IN_W-1:0] yrs,
    input logic [MONTH_W-1:0]   mon,
    input logic [DAY_W-1:0]     mday,
    input logic [HOUR_W-1:0]    hr,
    input logic [MIN_W-1:0]     mn,
    input logic [SEC_W-1:0]     sc
  );
    epoch_t            res;
    int unsigned       year;
    int unsigned       month_days;
    longint unsigned   days;
    longint unsigned   secs;
    bit                leap;
    bit                ok;
    year = int'(BASE_YEAR) + int'(yrs);
    leap = leap_year(year);
    ok   = (year >= int'(EPOCH_YEAR)) && (mon <= MONTH_LAST) &&
           (hr <= LAST_HOUR) && (mn <= LAST_MINUTE) && (sc <= LAST_SECOND);
    if (ok) begin
      month_days = DAYS_IN_MONTH[mon] + ((leap && mon == MONTH_FEB) ? 1 : 0);
      if (mday == 0 || mday > month_days) ok = 0;
    end
    res = '0;
    if (ok) begin
      days = longint'(year - int'(EPOCH_YEAR)) * 365 + longint'(mday) - 1;
      for (int m = 0; m < int'(mon); m++) days += DAYS_IN_MONTH[m];
      days += leap_days_through(year - 1) - leap_days_through(int'(EPOCH_YEAR) - 1);
      if (leap && mon >= MONTH_MAR) days += 1;
      secs     = ((days * 24 + hr) * 60 + mn) * 60 + sc;
      res.secs = secs[SECS_W-1:0];
      res.ok   = 1'b1;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin
    epoch_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        epoch_q.push_back(civil_to_epoch(years_since_1900, month_index, day_of_month,
                                         hour_of_day, minute_of_hour, second_of_minute));
      end
      if (out_valid && !out_stall) begin
        if (epoch_q.size() == 0) begin
          report_mismatch("unexpected item", epoch_seconds, 0);
        end else begin
          want = epoch_q.pop_front();
          if (epoch_seconds !== want.secs)
            report_mismatch("epoch_seconds", epoch_seconds, want.secs);
          if (time_valid !== want.ok)
            report_mismatch("time_valid", time_valid, want.ok);
        end
      end
      wait_count = epoch_q.size();
    end
  end

endmodule

@@ verif/tb_broken_down_time_to_epoch_seconds.sv @@
// ----------------------------------------------------------------------------
// tb_broken_down_time_to_epoch_seconds
// Drives calendar times into the converter: a directed set of boundary
// dates and rejected fields, then random times, mostly well formed, under
// random idling on both channels, a long output hold-off and a full drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_broken_down_time_to_epoch_seconds;
  import bdt_pkg::*;

  localparam int RANDOM_ITEMS = 1930;
  localparam int CALM_FIRST   = 500;
  localparam int CALM_LAST    = 800;
  localparam int HOLD_AT      = 1100;
  localparam int DRAIN_AT     = 1500;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 3000;
  localparam int IDLE_PCT     = 37;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [YEAR_IN_W-1:0] years_since_1900;
  logic [MONTH_W-1:0]   month_index;
  logic [DAY_W-1:0]     day_of_month;
  logic [HOUR_W-1:0]    hour_of_day;
  logic [MIN_W-1:0]     minute_of_hour;
  logic [SEC_W-1:0]     second_of_minute;
  logic                 out_valid;
  logic                 out_stall;
  logic [SECS_W-1:0]    epoch_seconds;
  logic                 time_valid;
  int                   mismatches;
  int                   outstanding;

  bit calm = 0;
  bit hold_pending = 0;

  broken_down_time_to_epoch_seconds i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .years_since_1900 (years_since_1900),
    .month_index      (month_index),
    .day_of_month     (day_of_month),
    .hour_of_day      (hour_of_day),
    .minute_of_hour   (minute_of_hour),
    .second_of_minute (second_of_minute),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .epoch_seconds    (epoch_seconds),
    .time_valid       (time_valid)
  );

  bdt_epoch_checker i_checker (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .years_since_1900 (years_since_1900),
    .month_index      (month_index),
    .day_of_month     (day_of_month),
    .hour_of_day      (hour_of_day),
    .minute_of_hour   (minute_of_hour),
    .second_of_minute (second_of_minute),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .epoch_seconds    (epoch_seconds),
    .time_valid       (time_valid),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  task automatic send_time(input int yrs, input int mon, input int mday,
                           input int hr, input int mn, input int sc);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    years_since_1900 <= yrs[YEAR_IN_W-1:0];
    month_index      <= mon[MONTH_W-1:0];
    day_of_month     <= mday[DAY_W-1:0];
    hour_of_day      <= hr[HOUR_W-1:0];
    minute_of_hour   <= mn[MIN_W-1:0];
    second_of_minute <= sc[SEC_W-1:0];
    in_valid         <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // receiver: random stall, calm stretch, one long hold-off
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAIL broken_down_time_to_epoch_seconds");
    $finish;
  end

  initial begin : stimulus
    int sel;
    rst              = 1'b1;
    in_valid         = 1'b0;
    years_since_1900 = '0;
    month_index      = '0;
    day_of_month     = '0;
    hour_of_day      = '0;
    minute_of_hour   = '0;
    second_of_minute = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_time(70, 0, 1, 0, 0, 0);
    send_time(8191, 11, 31, 23, 59, 59);
    send_time(69, 11, 31, 23, 59, 59);
    send_time(0, 0, 1, 0, 0, 0);
    send_time(8191, 15, 63, 31, 63, 63);
    send_time(120, 12, 1, 0, 0, 0);
    send_time(120, 15, 1, 0, 0, 0);
    send_time(120, 0, 0, 0, 0, 0);
    send_time(120, 0, 32, 0, 0, 0);
    send_time(120, 3, 31, 0, 0, 0);
    send_time(100, 1, 29, 12, 0, 0);
    send_time(104, 1, 29, 0, 0, 0);
    send_time(101, 1, 29, 0, 0, 0);
    send_time(200, 1, 29, 0, 0, 0);
    send_time(200, 1, 28, 23, 59, 59);
    send_time(200, 2, 1, 0, 0, 0);
    send_time(100, 2, 1, 0, 0, 0);
    send_time(500, 1, 29, 6, 30, 30);
    send_time(100, 11, 31, 23, 59, 59);
    send_time(124, 5, 15, 24, 0, 0);
    send_time(124, 5, 15, 0, 60, 0);
    send_time(124, 5, 15, 0, 0, 60);
    send_time(124, 5, 15, 23, 59, 59);

    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == CALM_FIRST) calm = 1;
      if (n == CALM_LAST) calm = 0;
      if (n == HOLD_AT) hold_pending = 1;
      if (n == DRAIN_AT) begin
        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
      end
      sel = $urandom_range(99);
      if (sel < 75) begin
        send_time(($urandom_range(3) == 0) ? $urandom_range(70, 330)
                                           : $urandom_range(70, 8191),
                  $urandom_range(11), $urandom_range(1, 31),
                  $urandom_range(23), $urandom_range(59), $urandom_range(59));
      end else begin
        send_time($urandom_range(8191), $urandom_range(15), $urandom_range(63),
                  $urandom_range(31), $urandom_range(63), $urandom_range(63));
      end
    end

    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("PASS broken_down_time_to_epoch_seconds");
    else
      $display("FAIL broken_down_time_to_epoch_seconds");
    $finish;
  end

endmodule

@@ files.f @@
rtl/bdt_pkg.sv
rtl/bdt_div100.sv
rtl/broken_down_time_to_epoch_seconds.sv
verif/bdt_epoch_checker.sv
verif/tb_broken_down_time_to_epoch_seconds.sv
